// File: rtl/core/pipc_pkg.sv
// Shared types and constants for the clamped PI/PID controller.
package pipc_pkg;

	// Configuration register indexes, in register-map order.
	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_KP_GAIN   = 3'd1,
		REG_KI_GAIN   = 3'd2,
		REG_KD_GAIN   = 3'd3,
		REG_INTEG_MIN = 3'd4,
		REG_INTEG_MAX = 3'd5,
		REG_DRIVE_MIN = 3'd6,
		REG_DRIVE_MAX = 3'd7
	} cfg_idx_t;

	// Operating mode codes; the unused code behaves as calibration PI.
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_CAL    = 2'd1;
	localparam logic [1:0] MODE_PID    = 2'd2;

	localparam int CFG_DATA_W = 32;

	// Deadband limit and the reduced integral gain used inside it (ki * 3277 / 65536).
	localparam logic signed [16:0] DEADBAND    = 17'sd100;
	localparam logic signed [12:0] DB_KI_NUM   = 13'sd3277;
	localparam int                 DB_KI_SHIFT = 16;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        kp_gain;
		logic [15:0]        ki_gain;
		logic [15:0]        kd_gain;
		logic signed [31:0] integ_min;
		logic signed [31:0] integ_max;
		logic signed [31:0] drive_min;
		logic [30:0]        drive_max;
	} cfg_regs_t;

endpackage

// File: rtl/core/pipc_if.sv
// Valid/ready stream interfaces for the controller's input and result channels.
interface pipc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] setpoint;
	logic signed [15:0] feedback;

	modport source(output valid, output setpoint, output feedback, input ready);
	modport sink(input valid, input setpoint, input feedback, output ready);
endinterface

interface pipc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;
	logic signed [16:0] error_value;

	modport source(output valid, output drive, output error_value, input ready);
	modport sink(input valid, input drive, input error_value, output ready);
endinterface

// File: rtl/core/pipc_cfg_regs.sv
// Configuration register file of the controller.
module pipc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  pipc_pkg::cfg_idx_t                 cfg_index,
	input  logic [pipc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pipc_pkg::cfg_regs_t                regs
);
	import pipc_pkg::*;

	cfg_regs_t regs_q;

	// Each write updates the addressed register; reset loads the open limits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode      <= MODE_NORMAL;
			regs_q.kp_gain   <= '0;
			regs_q.ki_gain   <= '0;
			regs_q.kd_gain   <= '0;
			regs_q.integ_min <= 32'sh8000_0000;
			regs_q.integ_max <= 32'sh7fff_ffff;
			regs_q.drive_min <= 32'sh8000_0000;
			regs_q.drive_max <= 31'h7fff_ffff;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      regs_q.mode      <= cfg_data[1:0];
				REG_KP_GAIN:   regs_q.kp_gain   <= cfg_data[15:0];
				REG_KI_GAIN:   regs_q.ki_gain   <= cfg_data[15:0];
				REG_KD_GAIN:   regs_q.kd_gain   <= cfg_data[15:0];
				REG_INTEG_MIN: regs_q.integ_min <= signed'(cfg_data[31:0]);
				REG_INTEG_MAX: regs_q.integ_max <= signed'(cfg_data[31:0]);
				REG_DRIVE_MIN: regs_q.drive_min <= signed'(cfg_data[31:0]);
				REG_DRIVE_MAX: regs_q.drive_max <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// File: rtl/core/pi_pid_controller_clamped_top.sv
// Clamped PI/PID controller: five-stage pipeline, one transaction per cycle unless out_ch.ready stalls it.
// Each accepted input transaction moves through the stage 1 to stage 5 registers to the result port.
// Throughput: one transaction per cycle unless out_ch.ready stalls the pipeline; the integrator update
// is a single add-and-clamp in stage 4, so it never holds back the next item.
// Reset (arst_n low, asynchronous): pipeline emptied, integrator and last error
// cleared, configuration returned to its default values.
module pi_pid_controller_clamped_top (
	input  logic                            clk,
	input  logic                            arst_n,
	pipc_in_if.sink                         in_ch,
	pipc_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  pipc_pkg::cfg_idx_t              cfg_index,
	input  logic [pipc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pipc_pkg::*;

	cfg_regs_t cfg;

	pipc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (cfg)
	);

	// Stage valids and load enables; a stage loads when it is empty or moves on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic in_accept;

	assign en5 = !v_s5 || out_ch.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;
	assign in_accept = in_ch.valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Stage 1: error, deadband test and the change in error against the last one.
	logic signed [16:0] err_in;
	logic signed [17:0] diff_in;
	logic               db_in;
	logic signed [16:0] last_error_q;
	logic signed [16:0] err_s1;
	logic signed [17:0] diff_s1;
	logic               db_s1;

	assign err_in  = 17'(in_ch.setpoint) - 17'(in_ch.feedback);
	assign diff_in = 18'(err_in) - 18'(last_error_q);
	assign db_in   = (cfg.mode == MODE_NORMAL) && (err_in > -DEADBAND) && (err_in < DEADBAND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
		end else if (in_accept && cfg.mode == MODE_PID) begin
			last_error_q <= err_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			err_s1  <= err_in;
			diff_s1 <= diff_in;
			db_s1   <= db_in;
		end
	end

	// Stage 2: the three gain products.
	logic signed [16:0] kp_s, ki_s, kd_s;
	logic signed [32:0] pprod, iprod;
	logic signed [33:0] dprod;
	logic signed [32:0] pprod_s2, iprod_s2;
	logic signed [33:0] dprod_s2;
	logic signed [16:0] err_s2;
	logic               db_s2;

	assign kp_s  = signed'({1'b0, cfg.kp_gain});
	assign ki_s  = signed'({1'b0, cfg.ki_gain});
	assign kd_s  = signed'({1'b0, cfg.kd_gain});
	assign pprod = db_s1 ? 33'sd0 : err_s1 * kp_s;
	assign iprod = err_s1 * ki_s;
	assign dprod = (cfg.mode == MODE_PID) ? diff_s1 * kd_s : 34'sd0;

	always_ff @(posedge clk) begin
		if (en2) begin
			pprod_s2 <= pprod;
			iprod_s2 <= iprod;
			dprod_s2 <= dprod;
			err_s2   <= err_s1;
			db_s2    <= db_s1;
		end
	end

	// Stage 3: reduced integral term in the deadband, and proportional plus derivative.
	// Inside the deadband the error is below 100, so the product fits in 24 bits.
	logic signed [36:0] db_prod;
	logic signed [32:0] iterm;
	logic signed [34:0] pd_sum;
	logic signed [32:0] iterm_s3;
	logic signed [34:0] pd_s3;
	logic signed [16:0] err_s3;

	assign db_prod = signed'(iprod_s2[23:0]) * DB_KI_NUM;
	assign iterm   = db_s2 ? 33'(signed'(db_prod[36:DB_KI_SHIFT])) : iprod_s2;
	assign pd_sum  = 35'(pprod_s2) + 35'(dprod_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			iterm_s3 <= iterm;
			pd_s3    <= pd_sum;
			err_s3   <= err_s2;
		end
	end

	// Stage 4: integrator accumulate, lower limit first, then upper limit.
	// The integrator register holds the value that belongs to the item in stage 4.
	logic signed [33:0] integ_sum;
	logic signed [31:0] integ_next;
	logic signed [31:0] integ_q;
	logic signed [34:0] pd_s4;
	logic signed [16:0] err_s4;

	assign integ_sum = 34'(integ_q) + 34'(iterm_s3);

	always_comb begin
		if (integ_sum < 34'(cfg.integ_min)) begin
			integ_next = cfg.integ_min;
		end else begin
			integ_next = integ_sum[31:0];
		end
		if (integ_sum > 34'(cfg.integ_max) || cfg.integ_min > cfg.integ_max) begin
			integ_next = cfg.integ_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (en4 && v_s3) begin
			integ_q <= integ_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			pd_s4  <= pd_s3;
			err_s4 <= err_s3;
		end
	end

	// Stage 5: drive sum and output clamp into the result register.
	logic signed [35:0] drive_sum;
	logic signed [35:0] hi_lim, lo_lim;
	logic signed [31:0] drive_next;
	logic signed [31:0] drive_s5;
	logic signed [16:0] err_s5;

	assign drive_sum = 36'(pd_s4) + 36'(integ_q);
	assign hi_lim    = signed'({5'b0, cfg.drive_max});
	assign lo_lim    = (cfg.mode == MODE_PID) ? -hi_lim : 36'(cfg.drive_min);

	always_comb begin
		if (drive_sum > hi_lim) begin
			drive_next = 32'(hi_lim);
		end else begin
			drive_next = drive_sum[31:0];
		end
		if (drive_sum < lo_lim || lo_lim > hi_lim) begin
			drive_next = 32'(lo_lim);
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			drive_s5 <= drive_next;
			err_s5   <= err_s4;
		end
	end

	assign out_ch.valid       = v_s5;
	assign out_ch.drive       = drive_s5;
	assign out_ch.error_value = err_s5;

endmodule

// File: rtl/core/pipc_checker.sv
// Port-level checks for the controller, attached to the top level by bind.
module pipc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] drive,
	input logic signed [16:0] error_value
);

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(drive) && $stable(error_value))
		else $error("result payload changed while stalled");

	// Reset empties the pipeline.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	// The difference of two 16-bit samples never reaches the most negative 17-bit code.
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_value != 17'sh10000)
		else $error("error value out of range");

endmodule

bind pi_pid_controller_clamped_top pipc_checker u_pipc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.drive       (out_ch.drive),
	.error_value (out_ch.error_value)
);

// File: sim/tb_pi_pid_controller_clamped_top.sv
// Self-checking testbench for the clamped PI/PID controller top level.
`timescale 1ns / 100ps

module tb_pi_pid_controller_clamped_top;
	import pipc_pkg::*;

	// The spare mode code behaves as calibration PI.
	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam int         PIPE_LATENCY = 4;
	localparam int         LIMIT_CYCLES = 200000;
	localparam int         REPORT_MAX   = 10;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [16:0] error_value;
	} ctrl_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pipc_in_if  in_bus();
	pipc_out_if res_bus();

	// Shadow of the controller: configuration, integrator and last error.
	cfg_regs_t cfg_shadow;
	longint    integ_acc;
	longint    prev_error;

	ctrl_result_t drive_queue[$];
	int unsigned  mismatch_count;
	int unsigned  cycle_count;
	int unsigned  hold_request;
	bit           gaps_on;

	pi_pid_controller_clamped_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_bus),
		.out_ch    (res_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generator.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit; a hung pipeline ends the run here.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Computes one control step and advances the shadow state.
	function automatic ctrl_result_t compute_drive(logic signed [15:0] sp,
			logic signed [15:0] fb);
		longint err, p_term, i_term, d_term, total, cap;
		ctrl_result_t r;
		err = longint'(sp) - longint'(fb);
		if (cfg_shadow.mode == MODE_NORMAL && err > -longint'(DEADBAND) &&
				err < longint'(DEADBAND)) begin
			p_term = 0;
			i_term = (err * longint'(cfg_shadow.ki_gain) * longint'(DB_KI_NUM)) >>> DB_KI_SHIFT;
		end else begin
			p_term = err * longint'(cfg_shadow.kp_gain);
			i_term = err * longint'(cfg_shadow.ki_gain);
		end

		// Integrator clamp: lower limit first, then upper.
		integ_acc = integ_acc + i_term;
		if (integ_acc < longint'(cfg_shadow.integ_min))
			integ_acc = longint'(cfg_shadow.integ_min);
		if (integ_acc > longint'(cfg_shadow.integ_max))
			integ_acc = longint'(cfg_shadow.integ_max);

		cap = longint'(cfg_shadow.drive_max);
		if (cfg_shadow.mode == MODE_PID) begin
			d_term = (err - prev_error) * longint'(cfg_shadow.kd_gain);
			prev_error = err;
			total = p_term + integ_acc + d_term;
			if (total > cap)
				total = cap;
			if (total < -cap)
				total = -cap;
		end else begin
			total = p_term + integ_acc;
			if (total > cap)
				total = cap;
			if (total < longint'(cfg_shadow.drive_min))
				total = longint'(cfg_shadow.drive_min);
		end
		r.drive = total[31:0];
		r.error_value = err[16:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%s mismatch: expected %0d, actual %0d", what, want, got);
	endtask

	// Result side: random stalls, long hold-off on request, and the checker.
	initial begin : result_monitor
		int unsigned stall_left;
		ctrl_result_t want;
		stall_left = 0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
				if (drive_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("unexpected result transaction: drive %0d, error %0d",
							res_bus.drive, res_bus.error_value);
				end else begin
					want = drive_queue.pop_front();
					if (res_bus.drive !== want.drive)
						report_mismatch("drive", want.drive, res_bus.drive);
					if (res_bus.error_value !== want.error_value)
						report_mismatch("error_value", want.error_value, res_bus.error_value);
				end
			end
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= !(gaps_on && $urandom_range(0, 99) < 15);
			end
		end
	end

	// Offers one sample, waits for its transaction and records the expectation.
	// Valid stays high afterwards so that back-to-back samples need no toggle.
	task automatic send_sample(logic signed [15:0] sp, logic signed [15:0] fb);
		while (gaps_on && $urandom_range(0, 99) < 15) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid    <= 1'b1;
		in_bus.setpoint <= sp;
		in_bus.feedback <= fb;
		@(posedge clk);
		while (in_bus.ready !== 1'b1)
			@(posedge clk);
		drive_queue.push_back(compute_drive(sp, fb));
	endtask

	// Stops the stream and waits for every outstanding result.
	task automatic drain_pipeline();
		in_bus.valid <= 1'b0;
		while (drive_queue.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_MODE:      cfg_shadow.mode      = val[1:0];
			REG_KP_GAIN:   cfg_shadow.kp_gain   = val[15:0];
			REG_KI_GAIN:   cfg_shadow.ki_gain   = val[15:0];
			REG_KD_GAIN:   cfg_shadow.kd_gain   = val[15:0];
			REG_INTEG_MIN: cfg_shadow.integ_min = val;
			REG_INTEG_MAX: cfg_shadow.integ_max = val;
			REG_DRIVE_MIN: cfg_shadow.drive_min = val;
			REG_DRIVE_MAX: cfg_shadow.drive_max = val[30:0];
			default: ;
		endcase
	endtask

	// Rewrites the whole register map once the pipeline is empty.
	task automatic load_settings(logic [31:0] mode_v, logic [31:0] kp, logic [31:0] ki,
			logic [31:0] kd, logic [31:0] imin, logic [31:0] imax,
			logic [31:0] dmin, logic [31:0] dmax);
		drain_pipeline();
		write_reg(REG_MODE, mode_v);
		write_reg(REG_KP_GAIN, kp);
		write_reg(REG_KI_GAIN, ki);
		write_reg(REG_KD_GAIN, kd);
		write_reg(REG_INTEG_MIN, imin);
		write_reg(REG_INTEG_MAX, imax);
		write_reg(REG_DRIVE_MIN, dmin);
		write_reg(REG_DRIVE_MAX, dmax);
		cfg_we <= 1'b0;
	endtask

	// Random sample: a quarter near the deadband edge, some extremes, the rest anywhere.
	function automatic void pick_sample(output logic signed [15:0] sp,
			output logic signed [15:0] fb);
		int a, b, d;
		int ext [3];
		ext = '{-32768, 0, 32767};
		case ($urandom_range(0, 7))
			0, 1: begin
				a = int'($urandom_range(0, 65535)) - 32768;
				d = int'($urandom_range(0, 240)) - 120;
				b = a - d;
				if (b < -32768 || b > 32767)
					b = a + d;
			end
			2: begin
				a = ext[$urandom_range(0, 2)];
				b = ext[$urandom_range(0, 2)];
			end
			default: begin
				a = int'($urandom_range(0, 65535)) - 32768;
				b = int'($urandom_range(0, 65535)) - 32768;
			end
		endcase
		sp = a[15:0];
		fb = b[15:0];
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF;
			2: return $urandom_range(0, 1023);
			3: return $urandom_range(0, 255);
			default: return $urandom();
		endcase
	endfunction

	// Limit pairs: full range, random order (sometimes inverted), around zero, pinned.
	function automatic void pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
		case ($urandom_range(0, 4))
			0: begin
				lo = 32'h8000_0000;
				hi = 32'h7FFF_FFFF;
			end
			1: begin
				lo = $urandom();
				hi = $urandom();
			end
			2, 3: begin
				lo = -int'($urandom_range(0, 32'h0010_0000));
				hi = $urandom_range(0, 32'h0010_0000);
			end
			default: begin
				lo = $urandom_range(0, 4096);
				hi = lo;
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_drive_cap();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0;
			3: return $urandom();
			default: return $urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	// Normal PI: both sides of the deadband edge, negative flooring, extremes.
	task automatic test_deadband();
		load_settings(32'(MODE_NORMAL), 32'h0180, 32'h0200, 32'h0, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd99, 16'sd0);
		send_sample(16'sd100, 16'sd0);
		send_sample(16'sd0, 16'sd99);
		send_sample(16'sd0, 16'sd100);
		send_sample(-16'sd1, 16'sd0);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
	endtask

	// Calibration PI at full gains: the integrator and drive saturate both ways.
	task automatic test_calibration();
		load_settings(32'(MODE_CAL), 32'hFFFF, 32'hFFFF, 32'h0, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd50, 16'sd0);
	endtask

	// PID with the largest derivative gain against a symmetric limit.
	task automatic test_pid();
		load_settings(32'(MODE_PID), 32'h0100, 32'h0010, 32'hFFFF, 32'hFFFF_0000,
			32'h0001_0000, 32'h8000_0000, 32'h0010_0000);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd10, 16'sd5);
		send_sample(16'sd10, 16'sd5);
	endtask

	// Spare mode with inverted integrator and drive limits; drive_max bit 31 is ignored.
	task automatic test_spare_mode_inverted_limits();
		load_settings(32'(MODE_SPARE), 32'h0040, 32'h0100, 32'h0, 32'h0000_1000,
			32'hFFFF_F000, 32'h0000_0500, 32'h8000_0100);
		send_sample(16'sd100, 16'sd0);
		send_sample(-16'sd100, 16'sd0);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, -16'sd32768);
	endtask

	// Random register settings, every mode in turn, random samples with gaps.
	task automatic test_random_settings();
		logic [31:0] mode_v, imin, imax, dmin, spare;
		logic signed [15:0] sp, fb;
		for (int phase = 0; phase < 10; phase++) begin
			mode_v = 32'(phase % 4);
			if (phase >= 4)
				mode_v[31:2] = 30'($urandom());
			pick_bounds(imin, imax);
			pick_bounds(dmin, spare);
			load_settings(mode_v, pick_gain(), pick_gain(), pick_gain(), imin, imax,
				dmin, pick_drive_cap());
			for (int n = 0; n < 150; n++) begin
				pick_sample(sp, fb);
				send_sample(sp, fb);
			end
		end
	endtask

	// A long stretch at full rate on both sides.
	task automatic test_back_to_back();
		logic signed [15:0] sp, fb;
		gaps_on = 1'b0;
		load_settings(32'(MODE_PID), 32'h0020, 32'h0004, 32'h0080, 32'hFFF0_0000,
			32'h0010_0000, 32'h8000_0000, 32'h0100_0000);
		for (int n = 0; n < 300; n++) begin
			pick_sample(sp, fb);
			send_sample(sp, fb);
		end
		gaps_on = 1'b1;
	endtask

	// The result side holds off while samples keep coming, so the input must stall.
	task automatic test_backpressure();
		logic signed [15:0] sp, fb;
		load_settings(32'(MODE_CAL), 32'h0100, 32'h0008, 32'h0, 32'hFF00_0000,
			32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		gaps_on = 1'b0;
		hold_request = 400;
		for (int n = 0; n < 80; n++) begin
			pick_sample(sp, fb);
			send_sample(sp, fb);
		end
		gaps_on = 1'b1;
	endtask

	// Main sequence: reset, directed cases, then random traffic.
	initial begin
		mismatch_count = 0;
		hold_request   = 0;
		gaps_on        = 1'b1;
		cfg_shadow.mode      = MODE_NORMAL;
		cfg_shadow.kp_gain   = '0;
		cfg_shadow.ki_gain   = '0;
		cfg_shadow.kd_gain   = '0;
		cfg_shadow.integ_min = 32'h8000_0000;
		cfg_shadow.integ_max = 32'h7FFF_FFFF;
		cfg_shadow.drive_min = 32'h8000_0000;
		cfg_shadow.drive_max = 31'h7FFF_FFFF;
		integ_acc  = 0;
		prev_error = 0;

		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_MODE;
		cfg_data        <= '0;
		in_bus.valid    <= 1'b0;
		in_bus.setpoint <= '0;
		in_bus.feedback <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_deadband();
		test_calibration();
		test_pid();
		test_spare_mode_inverted_limits();
		test_random_settings();
		test_back_to_back();
		test_backpressure();

		drain_pipeline();
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (mismatch_count == 0 && drive_queue.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
